FILE: hw/rtl/tsts_pkg.sv
// tsts_pkg: shared types and constants of the two-sample t statistic unit
// used by tsts_ctrl, tsts_dp and two_sample_t_statistic_unit; no dependencies
package tsts_pkg;

	localparam int SAMPLE_W         = 24;
	localparam int LABEL_W          = 8;
	localparam int T_W              = 32;
	localparam int INDEX_W          = 8;
	localparam int DEF_MAX_SUBJECTS = 256;
	// rhs scale: 4 * 2^32 for Q16.16 with round to nearest
	localparam int RHS_SHIFT        = 34;
	// quotient is clipped to RAD_W bits, root has ROOT_W bits
	localparam int RAD_W            = 68;
	localparam int ROOT_W           = 34;

	localparam logic [INDEX_W-1:0] REG_FIRST_LABEL  = INDEX_W'(0);
	localparam logic [INDEX_W-1:0] REG_SECOND_LABEL = INDEX_W'(1);
	localparam logic [LABEL_W-1:0] FIRST_LABEL_RST  = LABEL_W'(0);
	localparam logic [LABEL_W-1:0] SECOND_LABEL_RST = LABEL_W'(1);

	typedef enum logic [3:0] {
		OP_NA_SQA,
		OP_SA_SQ,
		OP_DEVA_NB,
		OP_NB_SQB,
		OP_SB_SQ,
		OP_DEVB_NA,
		OP_V_N,
		OP_SA_NB,
		OP_SB_NA,
		OP_D_SQ,
		OP_R_N2
	} mul_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL_GO,
		ST_MUL_WAIT,
		ST_V_CHECK,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_SQRT_GO,
		ST_SQRT_WAIT,
		ST_EMIT,
		ST_EMIT_DEG
	} tsts_state_t;

	typedef struct packed {
		logic    accum;
		logic    mul_start;
		mul_op_t op;
		logic    div_start;
		logic    sqrt_start;
		logic    load_out;
		logic    deg;
		logic    clear;
	} tsts_cmd_t;

	typedef struct packed {
		logic few;
		logic v_zero;
		logic mul_done;
		logic div_done;
		logic sqrt_done;
		logic out_free;
	} tsts_sts_t;

endpackage

FILE: hw/rtl/tsts_ctrl.sv
// tsts_ctrl: sequencer of the t statistic unit
// depends on tsts_pkg; drives tsts_dp through tsts_cmd_t
module tsts_ctrl import tsts_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_last,
	input  tsts_sts_t sts,
	output tsts_cmd_t cmd,
	output logic      ready
);

	tsts_state_t state_q, state_d;
	mul_op_t     op_q, op_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_NA_SQA;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_last) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.few) begin
					state_d = ST_EMIT_DEG;
				end else begin
					op_d    = OP_NA_SQA;
					state_d = ST_MUL_GO;
				end
			end
			ST_MUL_GO: state_d = ST_MUL_WAIT;
			ST_MUL_WAIT: begin
				if (sts.mul_done) begin
					if (op_q == OP_DEVB_NA) begin
						state_d = ST_V_CHECK;
					end else if (op_q == OP_R_N2) begin
						state_d = ST_DIV_GO;
					end else begin
						op_d    = mul_op_t'(op_q + 4'd1);
						state_d = ST_MUL_GO;
					end
				end
			end
			ST_V_CHECK: begin
				if (sts.v_zero) begin
					state_d = ST_EMIT_DEG;
				end else begin
					op_d    = mul_op_t'(op_q + 4'd1);
					state_d = ST_MUL_GO;
				end
			end
			ST_DIV_GO: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (sts.div_done) state_d = ST_SQRT_GO;
			end
			ST_SQRT_GO: state_d = ST_SQRT_WAIT;
			ST_SQRT_WAIT: begin
				if (sts.sqrt_done) state_d = ST_EMIT;
			end
			ST_EMIT, ST_EMIT_DEG: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ready          = (state_q == ST_IDLE);
		cmd.accum      = (state_q == ST_IDLE) && in_valid;
		cmd.mul_start  = (state_q == ST_MUL_GO);
		cmd.op         = op_q;
		cmd.div_start  = (state_q == ST_DIV_GO);
		cmd.sqrt_start = (state_q == ST_SQRT_GO);
		cmd.load_out   = ((state_q == ST_EMIT) || (state_q == ST_EMIT_DEG)) && sts.out_free;
		cmd.deg        = (state_q == ST_EMIT_DEG);
		cmd.clear      = cmd.load_out;
	end

endmodule

FILE: hw/rtl/tsts_dp.sv
// tsts_dp: accumulators, shift-add multiplier, restoring divider, square root
// and output register of the t statistic unit; depends on tsts_pkg
module tsts_dp import tsts_pkg::*; #(
	parameter int MAX_SUBJECTS = DEF_MAX_SUBJECTS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [INDEX_W-1:0]  wr_index,
	input  logic [LABEL_W-1:0]  wr_data,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic [LABEL_W-1:0]  label,
	input  tsts_cmd_t           cmd,
	output tsts_sts_t           sts,
	output logic [T_W-1:0]      t_value,
	output logic                degenerate,
	output logic                out_valid,
	input  logic                out_ready
);

	localparam int CNT_W  = $clog2(MAX_SUBJECTS + 1);
	localparam int SUM_W  = SAMPLE_W + CNT_W;
	localparam int SQ_W   = 2 * SAMPLE_W - 2 + CNT_W;
	localparam int D_W    = SUM_W + CNT_W + 1;
	localparam int DW     = 2 * D_W + CNT_W + RHS_SHIFT - 1;
	localparam int DCNT_W = $clog2(DW + 1);
	localparam int SCNT_W = $clog2(ROOT_W + 1);
	localparam int RM_W   = ROOT_W + 2;

	localparam logic [ROOT_W:0] POS_LIM = (ROOT_W+1)'({1'b0, {(T_W-1){1'b1}}});
	localparam logic [ROOT_W:0] NEG_LIM = (ROOT_W+1)'({1'b1, {(T_W-1){1'b0}}});

	logic [LABEL_W-1:0] first_q, second_q;
	logic [CNT_W-1:0]   cnt_a_q, cnt_b_q;
	logic signed [SUM_W-1:0] sum_a_q, sum_b_q;
	logic [SQ_W-1:0]    sq_a_q, sq_b_q;

	logic signed [SAMPLE_W-1:0]   smp;
	logic signed [2*SAMPLE_W-1:0] smp_sq;
	logic                         hit_a, hit_b;
	logic [CNT_W:0]               ntot;
	logic [SUM_W-1:0]             mag_a, mag_b;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= FIRST_LABEL_RST;
			second_q <= SECOND_LABEL_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_FIRST_LABEL:  first_q  <= wr_data;
				REG_SECOND_LABEL: second_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign smp    = $signed(sample);
	assign smp_sq = smp * smp;
	assign hit_a  = (label == first_q) && (cnt_a_q < CNT_W'(MAX_SUBJECTS));
	assign hit_b  = (label != first_q) && (label == second_q)
		&& (cnt_b_q < CNT_W'(MAX_SUBJECTS));
	assign ntot   = (CNT_W+1)'(cnt_a_q) + (CNT_W+1)'(cnt_b_q);
	assign mag_a  = sum_a_q[SUM_W-1] ? SUM_W'(-sum_a_q) : SUM_W'(sum_a_q);
	assign mag_b  = sum_b_q[SUM_W-1] ? SUM_W'(-sum_b_q) : SUM_W'(sum_b_q);

	// per-group accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			sum_a_q <= '0;
			sum_b_q <= '0;
			sq_a_q  <= '0;
			sq_b_q  <= '0;
		end else if (cmd.clear) begin
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			sum_a_q <= '0;
			sum_b_q <= '0;
			sq_a_q  <= '0;
			sq_b_q  <= '0;
		end else if (cmd.accum) begin
			if (hit_a) begin
				cnt_a_q <= cnt_a_q + CNT_W'(1);
				sum_a_q <= sum_a_q + SUM_W'(smp);
				sq_a_q  <= sq_a_q + SQ_W'($unsigned(smp_sq));
			end else if (hit_b) begin
				cnt_b_q <= cnt_b_q + CNT_W'(1);
				sum_b_q <= sum_b_q + SUM_W'(smp);
				sq_b_q  <= sq_b_q + SQ_W'($unsigned(smp_sq));
			end
		end
	end

	// shift-add multiplier, one multiplier bit per cycle
	logic [DW-1:0]  m0_q, m1_q, lv_q;
	logic signed [D_W-1:0] d_q;
	logic [D_W-1:0] mag_d;
	logic [DW-1:0]  op_a, ma_q, mp_q;
	logic [D_W-1:0] op_b, mb_q;
	logic           mbusy_q, mul_done;
	logic signed [D_W-1:0] pd;

	assign mag_d = d_q[D_W-1] ? D_W'(-d_q) : D_W'(d_q);

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (cmd.op)
			OP_NA_SQA:  begin op_a = DW'(sq_a_q); op_b = D_W'(cnt_a_q); end
			OP_SA_SQ:   begin op_a = DW'(mag_a);  op_b = D_W'(mag_a);   end
			OP_DEVA_NB: begin op_a = m0_q;        op_b = D_W'(cnt_b_q); end
			OP_NB_SQB:  begin op_a = DW'(sq_b_q); op_b = D_W'(cnt_b_q); end
			OP_SB_SQ:   begin op_a = DW'(mag_b);  op_b = D_W'(mag_b);   end
			OP_DEVB_NA: begin op_a = m0_q;        op_b = D_W'(cnt_a_q); end
			OP_V_N:     begin op_a = m1_q;        op_b = D_W'(ntot);    end
			OP_SA_NB:   begin op_a = DW'(mag_a);  op_b = D_W'(cnt_b_q); end
			OP_SB_NA:   begin op_a = DW'(mag_b);  op_b = D_W'(cnt_a_q); end
			OP_D_SQ:    begin op_a = DW'(mag_d);  op_b = mag_d;         end
			OP_R_N2:    begin op_a = m0_q; op_b = D_W'(ntot - (CNT_W+1)'(2)); end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
		end else if (cmd.mul_start) begin
			mbusy_q <= 1'b1;
		end else if (mul_done) begin
			mbusy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			ma_q <= op_a;
			mb_q <= op_b;
			mp_q <= '0;
		end else if (mbusy_q && (mb_q != '0)) begin
			mp_q <= mp_q + (mb_q[0] ? ma_q : '0);
			ma_q <= ma_q << 1;
			mb_q <= mb_q >> 1;
		end
	end

	assign mul_done = mbusy_q && (mb_q == '0);
	assign pd       = $signed(mp_q[D_W-1:0]);

	// product write-back
	always_ff @(posedge clk) begin
		if (mul_done) begin
			case (cmd.op)
				OP_NA_SQA:  m0_q <= mp_q;
				OP_SA_SQ:   m0_q <= m0_q - mp_q;
				OP_DEVA_NB: m1_q <= mp_q;
				OP_NB_SQB:  m0_q <= mp_q;
				OP_SB_SQ:   m0_q <= m0_q - mp_q;
				OP_DEVB_NA: m1_q <= m1_q + mp_q;
				OP_V_N:     lv_q <= mp_q;
				OP_SA_NB:   d_q  <= sum_a_q[SUM_W-1] ? -pd : pd;
				OP_SB_NA:   d_q  <= sum_b_q[SUM_W-1] ? d_q + pd : d_q - pd;
				OP_D_SQ:    m0_q <= mp_q;
				OP_R_N2:    m0_q <= mp_q;
				default: ;
			endcase
		end
	end

	// restoring divider: rhs / (V * n), one quotient bit per cycle
	logic [DW-1:0]     dv_q, rem_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic              dbusy_q, div_done, dge;
	logic [DW:0]       r2;

	assign r2       = {rem_q, dv_q[DW-1]};
	assign dge      = r2 >= {1'b0, lv_q};
	assign div_done = dbusy_q && (dcnt_q == DCNT_W'(DW));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
		end else if (cmd.div_start) begin
			dbusy_q <= 1'b1;
		end else if (div_done) begin
			dbusy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dv_q   <= m0_q << RHS_SHIFT;
			rem_q  <= '0;
			dcnt_q <= '0;
		end else if (dbusy_q && !div_done) begin
			rem_q  <= dge ? DW'(r2 - {1'b0, lv_q}) : r2[DW-1:0];
			dv_q   <= {dv_q[DW-2:0], dge};
			dcnt_q <= dcnt_q + DCNT_W'(1);
		end
	end

	// integer square root of the clipped quotient, one root bit per cycle
	logic [RAD_W-1:0]  rad_in, rad_q;
	logic [ROOT_W-1:0] rt_q;
	logic [RM_W-1:0]   rm_q;
	logic [RM_W+1:0]   rm2, trial;
	logic [SCNT_W-1:0] scnt_q;
	logic              sbusy_q, sqrt_done, sge;

	assign rad_in    = (|dv_q[DW-1:RAD_W]) ? '1 : dv_q[RAD_W-1:0];
	assign rm2       = {rm_q, rad_q[RAD_W-1 -: 2]};
	assign trial     = (RM_W+2)'({rt_q, 2'b01});
	assign sge       = rm2 >= trial;
	assign sqrt_done = sbusy_q && (scnt_q == SCNT_W'(ROOT_W));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sbusy_q <= 1'b0;
		end else if (cmd.sqrt_start) begin
			sbusy_q <= 1'b1;
		end else if (sqrt_done) begin
			sbusy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sqrt_start) begin
			rad_q  <= rad_in;
			rt_q   <= '0;
			rm_q   <= '0;
			scnt_q <= '0;
		end else if (sbusy_q && !sqrt_done) begin
			rm_q   <= sge ? RM_W'(rm2 - trial) : RM_W'(rm2);
			rt_q   <= {rt_q[ROOT_W-2:0], sge};
			rad_q  <= rad_q << 2;
			scnt_q <= scnt_q + SCNT_W'(1);
		end
	end

	// largest m with (2m-1)^2 <= q is (root+1)/2, then signed saturation
	logic [ROOT_W:0] rnd, lim, mag_t;
	logic            neg;
	logic [T_W-1:0]  t_calc;

	assign neg    = d_q[D_W-1];
	assign rnd    = ({1'b0, rt_q} + (ROOT_W+1)'(1)) >> 1;
	assign lim    = neg ? NEG_LIM : POS_LIM;
	assign mag_t  = (rnd > lim) ? lim : rnd;
	assign t_calc = neg ? T_W'(-mag_t) : T_W'(mag_t);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			t_value    <= cmd.deg ? '0 : t_calc;
			degenerate <= cmd.deg;
		end
	end

	always_comb begin
		sts.few       = (cnt_a_q == '0) || (cnt_b_q == '0) || (ntot <= (CNT_W+1)'(2));
		sts.v_zero    = (m1_q == '0);
		sts.mul_done  = mul_done;
		sts.div_done  = div_done;
		sts.sqrt_done = sqrt_done;
		sts.out_free  = !out_valid || out_ready;
	end

endmodule

FILE: hw/rtl/two_sample_t_statistic_unit.sv
// throughput: one sample per cycle while a point accumulates
// after the last sample of a point, the result waits on the multiply ops of the shift-add multiplier,
//   the 128-step divider and the 34-step root
// a degenerate point (empty group, too few samples, or zero variance) gives a zero result, flagged
// no input is taken from the last sample until the result is loaded
// reset: arst_n async low clears accumulators, control and sets labels to 0 and 1
module two_sample_t_statistic_unit import tsts_pkg::*; #(
	parameter int MAX_SUBJECTS = DEF_MAX_SUBJECTS
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration write port
	input  logic                wr_en,
	input  logic [INDEX_W-1:0]  wr_index,
	input  logic [LABEL_W-1:0]  wr_data,
	// sample stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [SAMPLE_W-1:0] s_tdata,   // sample [23:0]
	input  logic [LABEL_W-1:0]  s_tuser,   // label [7:0]
	input  logic                s_tlast,
	// result stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [T_W-1:0]      m_tdata,   // t_value [31:0]
	output logic                m_tuser    // degenerate [0]
);

	tsts_cmd_t cmd;
	tsts_sts_t sts;

	// sequencer: accepts samples in idle, walks the multiply ops, divide, root
	tsts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.sts      (sts),
		.cmd      (cmd),
		.ready    (s_tready)
	);

	// datapath: label registers, group sums, arithmetic units, result register
	tsts_dp #(
		.MAX_SUBJECTS (MAX_SUBJECTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.sample     (s_tdata),
		.label      (s_tuser),
		.cmd        (cmd),
		.sts        (sts),
		.t_value    (m_tdata),
		.degenerate (m_tuser),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready)
	);

`ifndef ASSERT_OFF
	// a degenerate result always carries a zero statistic
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("degenerate result with nonzero t");

	// the transfer of a last sample closes the input
	a_last_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("input taken while a point is being evaluated");

	// a result is only loaded into a free output slot
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (sts.out_free && !s_tready))
		else $error("result loaded over a pending transfer");
`endif

endmodule
